// ===== sv/mop_pkg.sv =====
package mop_pkg;

  localparam int unsigned CNT_W     = 16;
  localparam int unsigned MA_W      = 15;
  localparam int unsigned SPEED_W   = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Input command codes; the fourth code is unused and changes nothing.
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_SAMPLE = 2'd1;
  localparam logic [1:0] CMD_EDGE   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SURGE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HYST      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_SPEED = 3'd5;

  localparam logic [CNT_W-1:0]   DEBOUNCE_RST  = 16'd50;
  localparam logic [CNT_W-1:0]   SURGE_RST     = 16'd500;
  localparam logic [MA_W-1:0]    LIMIT_RST     = 15'd2000;
  localparam logic [MA_W-1:0]    LOW_THR_RST   = 15'd200;
  localparam logic [MA_W-1:0]    HYST_RST      = 15'd50;
  localparam logic [SPEED_W-1:0] RUN_SPEED_RST = 8'd200;

  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_RUNNING = 2'd1,
    MODE_LOW     = 2'd2,
    MODE_TRIPPED = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_BRAKE   = 2'd1,
    ACT_FORWARD = 2'd2
  } act_e;

  localparam logic [3:0] LAMP_RUNNING = 4'b0001;
  localparam logic [3:0] LAMP_STOPPED = 4'b0010;
  localparam logic [3:0] LAMP_TRIPPED = 4'b0100;
  localparam logic [3:0] LAMP_LOW     = 4'b1000;

  typedef struct packed {
    logic [CNT_W-1:0]   debounce_ms;
    logic [CNT_W-1:0]   surge_ignore_ms;
    logic [MA_W-1:0]    current_limit_ma;
    logic [MA_W-1:0]    low_threshold_ma;
    logic [MA_W-1:0]    hysteresis_ma;
    logic [SPEED_W-1:0] run_speed;
  } cfg_t;

  typedef struct packed {
    mode_e            mode;
    logic [CNT_W-1:0] since_edge_ms;
    logic [CNT_W-1:0] since_start_ms;
  } state_t;

  typedef struct packed {
    mode_e              mode;
    logic [3:0]         lamps;
    act_e               motor_action;
    logic [SPEED_W-1:0] motor_speed;
    logic               trip;
    logic               edge_taken;
  } result_t;

  function automatic logic [3:0] lamp_bits(mode_e m);
    logic [3:0] l;
    unique case (m)
      MODE_RUNNING: l = LAMP_RUNNING;
      MODE_STOPPED: l = LAMP_STOPPED;
      MODE_TRIPPED: l = LAMP_TRIPPED;
      MODE_LOW:     l = LAMP_LOW;
      default:      l = LAMP_STOPPED;
    endcase
    return l;
  endfunction

endpackage

// ===== sv/mop_if.sv =====
interface mop_in_if;
  import mop_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic signed [15:0] current_ma;

  modport source (output valid, output cmd, output current_ma, input ready);
  modport sink   (input valid, input cmd, input current_ma, output ready);
endinterface

interface mop_res_if;
  import mop_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [3:0]         lamps;
  logic [1:0]         motor_action;
  logic [SPEED_W-1:0] motor_speed;
  logic               trip;
  logic               edge_taken;

  modport source (output valid, output mode, output lamps, output motor_action,
                  output motor_speed, output trip, output edge_taken, input ready);
  modport sink   (input valid, input mode, input lamps, input motor_action,
                  input motor_speed, input trip, input edge_taken, output ready);
endinterface

interface mop_cfg_if;
  import mop_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/mop_step.sv =====
module mop_step (
  input  mop_pkg::cfg_t    cfg_i,
  input  mop_pkg::state_t  state_i,
  input  logic [1:0]       cmd_i,
  input  logic signed [15:0] current_ma_i,
  output mop_pkg::state_t  state_o,
  output mop_pkg::result_t result_o
);
  import mop_pkg::*;

  logic [MA_W+1:0] mag;
  logic [MA_W+1:0] band_hi;
  logic [MA_W-1:0] band_lo;
  logic            armed;
  logic            over;
  logic            below_band;
  logic            above_band;
  logic            motor_on;
  logic            debounced;

  // Magnitude needs 17 bits: the most negative sample gives 32768.
  assign mag = current_ma_i[15] ? (17'h10000 - {1'b0, current_ma_i})
                                : {1'b0, current_ma_i};

  assign armed      = state_i.since_start_ms > cfg_i.surge_ignore_ms;
  assign over       = mag > {2'b00, cfg_i.current_limit_ma};
  assign band_lo    = cfg_i.low_threshold_ma - cfg_i.hysteresis_ma;
  assign band_hi    = {2'b00, cfg_i.low_threshold_ma} + {2'b00, cfg_i.hysteresis_ma};
  assign below_band = (cfg_i.low_threshold_ma > cfg_i.hysteresis_ma) &&
                      (mag < {2'b00, band_lo});
  assign above_band = mag > band_hi;
  assign motor_on   = (state_i.mode == MODE_RUNNING) || (state_i.mode == MODE_LOW);
  assign debounced  = state_i.since_edge_ms >= cfg_i.debounce_ms;

  always_comb begin
    state_o               = state_i;
    result_o.motor_action = ACT_NONE;
    result_o.motor_speed  = '0;
    result_o.trip         = 1'b0;
    result_o.edge_taken   = 1'b0;

    unique case (cmd_i)
      CMD_TICK: begin
        if (state_i.since_edge_ms != CNT_MAX) begin
          state_o.since_edge_ms = state_i.since_edge_ms + 1'b1;
        end
        if (state_i.since_start_ms != CNT_MAX) begin
          state_o.since_start_ms = state_i.since_start_ms + 1'b1;
        end
      end
      CMD_EDGE: begin
        if (debounced) begin
          result_o.edge_taken   = 1'b1;
          state_o.since_edge_ms = '0;
          if (motor_on) begin
            result_o.motor_action = ACT_BRAKE;
            state_o.mode          = MODE_STOPPED;
          end else begin
            result_o.motor_action  = ACT_FORWARD;
            result_o.motor_speed   = cfg_i.run_speed;
            state_o.since_start_ms = '0;
            state_o.mode           = MODE_RUNNING;
          end
        end
      end
      CMD_SAMPLE: begin
        if (motor_on) begin
          priority if (armed && over) begin
            result_o.motor_action = ACT_BRAKE;
            result_o.trip         = 1'b1;
            state_o.mode          = MODE_TRIPPED;
          end else if (below_band) begin
            state_o.mode = MODE_LOW;
          end else if (above_band) begin
            state_o.mode = MODE_RUNNING;
          end else begin
            state_o.mode = state_i.mode;
          end
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase

    result_o.mode  = state_o.mode;
    result_o.lamps = lamp_bits(state_o.mode);
  end

endmodule

// ===== sv/motor_overcurrent_protection_fsm.sv =====
// Channel   Dir  Beat contents
// in_i      in   cmd (tick, current sample, button edge), current_ma
// res_o     out  mode, lamps, motor_action, motor_speed, trip, edge_taken
// cfg_i     in   index, data (register write, always ready)
//
// One item per clock cycle sustained while res_o.ready is high; a result passes the input
// register and then the result register, a two-stage pipeline, so a new beat is taken while
// a result waits if the input register is empty; both stages stall only on res_o.ready.
// Reset sets the register defaults, mode stopped and the edge counter saturated.
module motor_overcurrent_protection_fsm (
  input  logic  clk_i,
  input  logic  rst_ni,
  mop_in_if.sink     in_i,
  mop_res_if.source  res_o,
  mop_cfg_if.sink    cfg_i
);
  import mop_pkg::*;

  cfg_t               cfg_q;
  state_t             state_q;
  state_t             state_d;
  result_t            result_d;
  result_t            result_q;
  logic               in_valid_q;
  logic [1:0]         cmd_q;
  logic signed [15:0] current_ma_q;
  logic               out_valid_q;
  logic               advance;
  logic               in_fire;

  assign advance     = !out_valid_q || res_o.ready;
  assign in_i.ready  = !in_valid_q || advance;
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  mop_step u_step (
    .cfg_i        (cfg_q),
    .state_i      (state_q),
    .cmd_i        (cmd_q),
    .current_ma_i (current_ma_q),
    .state_o      (state_d),
    .result_o     (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms      <= DEBOUNCE_RST;
      cfg_q.surge_ignore_ms  <= SURGE_RST;
      cfg_q.current_limit_ma <= LIMIT_RST;
      cfg_q.low_threshold_ma <= LOW_THR_RST;
      cfg_q.hysteresis_ma    <= HYST_RST;
      cfg_q.run_speed        <= RUN_SPEED_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_DEBOUNCE:  cfg_q.debounce_ms      <= cfg_i.data;
        REG_SURGE:     cfg_q.surge_ignore_ms  <= cfg_i.data;
        REG_LIMIT:     cfg_q.current_limit_ma <= cfg_i.data[MA_W-1:0];
        REG_LOW_THR:   cfg_q.low_threshold_ma <= cfg_i.data[MA_W-1:0];
        REG_HYST:      cfg_q.hysteresis_ma    <= cfg_i.data[MA_W-1:0];
        REG_RUN_SPEED: cfg_q.run_speed        <= cfg_i.data[SPEED_W-1:0];
        default:       cfg_q                  <= cfg_q;
      endcase
    end
  end

  // The state moves on when the item in the input register passes into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode           <= MODE_STOPPED;
      state_q.since_edge_ms  <= CNT_MAX;
      state_q.since_start_ms <= '0;
      in_valid_q             <= 1'b0;
      out_valid_q            <= 1'b0;
    end else begin
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
        if (in_valid_q) begin
          state_q <= state_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q        <= in_i.cmd;
      current_ma_q <= in_i.current_ma;
    end
    if (advance && in_valid_q) begin
      result_q <= result_d;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.mode         = result_q.mode;
  assign res_o.lamps        = result_q.lamps;
  assign res_o.motor_action = result_q.motor_action;
  assign res_o.motor_speed  = result_q.motor_speed;
  assign res_o.trip         = result_q.trip;
  assign res_o.edge_taken   = result_q.edge_taken;

endmodule

// ===== sv/mop_checker.sv =====
module mop_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        res_valid_i,
  input logic                        res_ready_i,
  input logic [1:0]                  res_mode_i,
  input logic [3:0]                  res_lamps_i,
  input logic [1:0]                  res_action_i,
  input logic [mop_pkg::SPEED_W-1:0] res_speed_i,
  input logic                        res_trip_i,
  input logic                        res_edge_taken_i
);
  import mop_pkg::*;

  // The lamp pattern always names the reported mode.
  a_lamps_follow_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |->
      ((res_mode_i == MODE_RUNNING) && (res_lamps_i == LAMP_RUNNING)) ||
      ((res_mode_i == MODE_STOPPED) && (res_lamps_i == LAMP_STOPPED)) ||
      ((res_mode_i == MODE_TRIPPED) && (res_lamps_i == LAMP_TRIPPED)) ||
      ((res_mode_i == MODE_LOW)     && (res_lamps_i == LAMP_LOW)))
    else $error("lamps do not match mode");

  // A trip always brakes and leaves the controller tripped, never on a button beat.
  a_trip_brakes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && res_trip_i) |->
      (res_mode_i == MODE_TRIPPED) && (res_action_i == ACT_BRAKE) && !res_edge_taken_i)
    else $error("trip without brake into tripped mode");

  // Forward drive comes only from a taken edge and starts the motor running.
  a_forward_from_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && (res_action_i == ACT_FORWARD)) |->
      res_edge_taken_i && (res_mode_i == MODE_RUNNING))
    else $error("forward command without a taken edge");

  a_speed_only_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && (res_speed_i != '0)) |-> (res_action_i == ACT_FORWARD))
    else $error("speed given without forward command");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=>
      res_valid_i && $stable(res_mode_i) && $stable(res_action_i) &&
      $stable(res_speed_i) && $stable(res_trip_i) && $stable(res_edge_taken_i))
    else $error("stalled result beat changed");

endmodule

bind motor_overcurrent_protection_fsm mop_checker u_mop_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .res_mode_i       (res_o.mode),
  .res_lamps_i      (res_o.lamps),
  .res_action_i     (res_o.motor_action),
  .res_speed_i      (res_o.motor_speed),
  .res_trip_i       (res_o.trip),
  .res_edge_taken_i (res_o.edge_taken)
);

// ===== tb/motor_overcurrent_protection_fsm_test.sv =====
`timescale 1ns / 100ps

module motor_overcurrent_protection_fsm_test;
  import mop_pkg::*;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         HOLD_CYCLES = 60;

  class trip_ledger;
    cfg_t             regs;
    mode_e            mode;
    logic [CNT_W-1:0] since_edge_ms;
    logic [CNT_W-1:0] since_start_ms;
    result_t          due_results[$];
    int               errors;

    function new();
      regs.debounce_ms      = DEBOUNCE_RST;
      regs.surge_ignore_ms  = SURGE_RST;
      regs.current_limit_ma = LIMIT_RST;
      regs.low_threshold_ma = LOW_THR_RST;
      regs.hysteresis_ma    = HYST_RST;
      regs.run_speed        = RUN_SPEED_RST;
      mode           = MODE_STOPPED;
      since_edge_ms  = CNT_MAX;
      since_start_ms = '0;
      errors         = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        REG_DEBOUNCE:  regs.debounce_ms      = data;
        REG_SURGE:     regs.surge_ignore_ms  = data;
        REG_LIMIT:     regs.current_limit_ma = data[MA_W-1:0];
        REG_LOW_THR:   regs.low_threshold_ma = data[MA_W-1:0];
        REG_HYST:      regs.hysteresis_ma    = data[MA_W-1:0];
        REG_RUN_SPEED: regs.run_speed        = data[SPEED_W-1:0];
        default: ;
      endcase
    endfunction

    // Works out the outcome of one accepted input beat and queues it.
    function void note_beat(logic [1:0] cmd, logic signed [15:0] cur);
      result_t     r;
      logic [16:0] mag;
      logic [16:0] band_top;
      logic        armed;
      r = '0;
      r.motor_action = ACT_NONE;
      case (cmd)
        CMD_TICK: begin
          if (since_edge_ms != CNT_MAX) since_edge_ms++;
          if (since_start_ms != CNT_MAX) since_start_ms++;
        end
        CMD_EDGE: begin
          if (since_edge_ms >= regs.debounce_ms) begin
            r.edge_taken  = 1'b1;
            since_edge_ms = '0;
            if (mode == MODE_RUNNING || mode == MODE_LOW) begin
              r.motor_action = ACT_BRAKE;
              mode = MODE_STOPPED;
            end else begin
              r.motor_action = ACT_FORWARD;
              r.motor_speed  = regs.run_speed;
              since_start_ms = '0;
              mode = MODE_RUNNING;
            end
          end
        end
        CMD_SAMPLE: begin
          if (mode == MODE_RUNNING || mode == MODE_LOW) begin
            // The most negative reading has a magnitude one above the largest limit.
            mag = cur[15] ? (17'h10000 - {1'b0, cur}) : {1'b0, cur};
            band_top = regs.low_threshold_ma + regs.hysteresis_ma;
            armed = since_start_ms > regs.surge_ignore_ms;
            if (armed && mag > regs.current_limit_ma) begin
              r.motor_action = ACT_BRAKE;
              r.trip = 1'b1;
              mode = MODE_TRIPPED;
            end else if (regs.low_threshold_ma > regs.hysteresis_ma &&
                         mag < regs.low_threshold_ma - regs.hysteresis_ma) begin
              mode = MODE_LOW;
            end else if (mag > band_top) begin
              mode = MODE_RUNNING;
            end
          end
        end
        default: ;
      endcase
      r.mode = mode;
      case (mode)
        MODE_RUNNING: r.lamps = LAMP_RUNNING;
        MODE_STOPPED: r.lamps = LAMP_STOPPED;
        MODE_TRIPPED: r.lamps = LAMP_TRIPPED;
        default:      r.lamps = LAMP_LOW;
      endcase
      due_results.push_back(r);
    endfunction

    function void check_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual %p", $time, got);
        errors++;
        return;
      end
      want = due_results.pop_front();
      check_field("mode", want.mode, got.mode);
      check_field("lamps", want.lamps, got.lamps);
      check_field("motor_action", want.motor_action, got.motor_action);
      check_field("motor_speed", want.motor_speed, got.motor_speed);
      check_field("trip", want.trip, got.trip);
      check_field("edge_taken", want.edge_taken, got.edge_taken);
    endfunction

    function int outstanding();
      return due_results.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   idle_on;
  bit   stall_req;
  int   hold_left;
  int   cycles;

  trip_ledger ledger;

  mop_in_if  in_if ();
  mop_res_if res_if ();
  mop_cfg_if cfg_if ();

  motor_overcurrent_protection_fsm dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** motor_overcurrent_protection_fsm: FAILED **");
      $finish;
    end
  end

  // Result side: random back-pressure, plus one long hold on request.
  always @(negedge clk_i) begin
    if (stall_req) begin
      hold_left = HOLD_CYCLES;
      stall_req = 1'b0;
    end
    if (hold_left > 0) begin
      res_if.ready = 1'b0;
      hold_left--;
    end else begin
      res_if.ready = !(idle_on && $urandom_range(99) < 23);
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) ledger.set_reg(cfg_if.index, cfg_if.data);
      if (in_if.valid && in_if.ready) ledger.note_beat(in_if.cmd, in_if.current_ma);
      if (res_if.valid && res_if.ready) begin
        got.mode         = mode_e'(res_if.mode);
        got.lamps        = res_if.lamps;
        got.motor_action = act_e'(res_if.motor_action);
        got.motor_speed  = res_if.motor_speed;
        got.trip         = res_if.trip;
        got.edge_taken   = res_if.edge_taken;
        ledger.check_result(got);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_item(logic [1:0] cmd, logic signed [15:0] cur);
    while (idle_on && $urandom_range(99) < 23) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid      = 1'b1;
    in_if.cmd        = cmd;
    in_if.current_ma = cur;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_if.valid = 1'b0;
    while (ledger.outstanding() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic apply_cfg(int deb, int surge, int limit, int low_thr, int hyst, int speed);
    wait_drained();
    repeat (4) @(negedge clk_i);
    write_reg(REG_DEBOUNCE, CFG_DAT_W'(deb));
    write_reg(REG_SURGE, CFG_DAT_W'(surge));
    write_reg(REG_LIMIT, CFG_DAT_W'(limit));
    write_reg(REG_LOW_THR, CFG_DAT_W'(low_thr));
    write_reg(REG_HYST, CFG_DAT_W'(hyst));
    write_reg(REG_RUN_SPEED, CFG_DAT_W'(speed));
  endtask

  // Readings cluster around the trip level and the band edges.
  function automatic logic signed [15:0] pick_current();
    int v;
    case ($urandom_range(7))
      0: return 16'($urandom);
      1: v = ledger.regs.current_limit_ma + $urandom_range(4) - 2;
      2: v = ledger.regs.low_threshold_ma - ledger.regs.hysteresis_ma + $urandom_range(4) - 2;
      3: v = ledger.regs.low_threshold_ma + ledger.regs.hysteresis_ma + $urandom_range(4) - 2;
      4: v = ledger.regs.low_threshold_ma + $urandom_range(6) - 3;
      5: return $urandom_range(1) ? 16'sh8000 : 16'sh7fff;
      default: v = $urandom_range(ledger.regs.current_limit_ma + ledger.regs.current_limit_ma / 4);
    endcase
    if ($urandom_range(1)) v = -v;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  task automatic run_random(int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 45) send_item(CMD_TICK, 16'($urandom));
      else if (pick < 85) send_item(CMD_SAMPLE, pick_current());
      else if (pick < 97) send_item(CMD_EDGE, 16'($urandom));
      else send_item(CMD_UNUSED, 16'($urandom));
    end
  endtask

  initial begin
    ledger = new();
    cycles = 0;
    hold_left = 0;
    stall_req = 1'b0;
    idle_on = 1'b1;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.cmd = CMD_TICK;
    in_if.current_ma = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_DEBOUNCE;
    cfg_if.data = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset settings: first edge is taken, a second one bounces.
    send_item(CMD_EDGE, 16'sd0);
    send_item(CMD_EDGE, 16'sd0);
    send_item(CMD_SAMPLE, 16'sd2100);
    send_item(CMD_SAMPLE, 16'sh8000);
    send_item(CMD_SAMPLE, 16'sd100);
    send_item(CMD_UNUSED, 16'sh7fff);
    send_item(CMD_SAMPLE, 16'sh7fff);

    apply_cfg(2, 3, 1000, 200, 50, 255);
    repeat (2) send_item(CMD_TICK, 16'sd0);
    send_item(CMD_EDGE, 16'sd0);
    send_item(CMD_SAMPLE, 16'sd5000);
    repeat (2) send_item(CMD_TICK, 16'sd0);
    send_item(CMD_EDGE, 16'sd0);
    repeat (4) send_item(CMD_TICK, 16'sd0);
    send_item(CMD_SAMPLE, 16'sd1001);
    send_item(CMD_SAMPLE, 16'sd0);
    repeat (2) send_item(CMD_TICK, 16'sd0);
    send_item(CMD_EDGE, 16'sd0);
    send_item(CMD_SAMPLE, -16'sd1000);

    // Every register at its minimum; the result side is held off midway.
    apply_cfg(0, 0, 0, 0, 0, 0);
    run_random(100);
    stall_req = 1'b1;
    run_random(100);

    // Every register at its maximum: the surge window never closes.
    apply_cfg(16'hffff, 16'hffff, 15'h7fff, 15'h7fff, 15'h7fff, 8'hff);
    run_random(100);

    for (int p = 0; p < 3; p++) begin
      apply_cfg($urandom_range(8), $urandom_range(30), $urandom_range(5000, 100),
                $urandom_range(1000), $urandom_range(300), $urandom_range(255));
      idle_on = (p != 1);
      run_random(100);
      idle_on = 1'b1;
      if (p == 2) wait_drained();
      run_random(100);
    end

    // Band lower edge below zero, so low current is never entered.
    apply_cfg(1, 5, 800, 30, 100, $urandom_range(255));
    run_random(100);

    wait_drained();
    repeat (8) @(negedge clk_i);
    if (ledger.errors == 0) begin
      $display("** motor_overcurrent_protection_fsm: PASSED **");
    end else begin
      $display("** motor_overcurrent_protection_fsm: FAILED **");
    end
    $finish;
  end

endmodule
